/* rtl/vector3_scaled_normalize_core_defines.svh */
// ----------------------------------------------------------------------------
// vector3_scaled_normalize_core_defines
// Assertion macros for the vector normalize core.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_SCALED_NORMALIZE_CORE_DEFINES_SVH
`define VECTOR3_SCALED_NORMALIZE_CORE_DEFINES_SVH

// implication in the same cycle, checked out of reset
`define VSN_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication into the next cycle, checked out of reset
`define VSN_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/vsn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsn_pkg
// Widths, sideband structs and the per-step functions of the square root and
// the long division used by the vector normalize pipeline.
// ----------------------------------------------------------------------------
package vsn_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW        = 32;          // component width
	localparam int TW        = 31;          // target length width
	localparam int SW        = 2 * CW;      // sum of squares width
	localparam int RW        = CW;          // root width
	localparam int RMW       = RW + 3;      // root remainder width
	localparam int NW        = CW + TW;     // numerator width
	localparam int QW        = TW;          // quotient width
	localparam int LANES     = 3;

	localparam logic [TW-1:0] TL_RESET = TW'(1) << FRAC_BITS;

	typedef struct packed {
		logic [LANES-1:0]         neg;
		logic [LANES-1:0][NW-1:0] num;
	} sqrt_side_t;

	typedef struct packed {
		logic [LANES-1:0] neg;
		logic             zero;
	} div_side_t;

	typedef struct packed {
		logic [RMW-1:0] rem;
		logic [RW-1:0]  root;
	} sqrt_acc_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [QW-1:0] quo;
	} div_acc_t;

	// one digit of the restoring square root
	function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
		sqrt_acc_t      r;
		logic [RMW-1:0] sh;
		logic [RMW-1:0] trial;
		sh    = {a.rem[RMW-3:0], pair};
		trial = RMW'({a.root, 2'b01});
		if (sh >= trial) begin
			r.rem  = sh - trial;
			r.root = {a.root[RW-2:0], 1'b1};
		end else begin
			r.rem  = sh;
			r.root = {a.root[RW-2:0], 1'b0};
		end
		return r;
	endfunction

	// one quotient bit of the restoring division
	function automatic div_acc_t div_step(div_acc_t a, logic nb, logic [RW-1:0] len);
		div_acc_t    r;
		logic [RW:0] t;
		t = {a.rem, nb};
		if (t >= {1'b0, len}) begin
			r.rem = RW'(t - {1'b0, len});
			r.quo = {a.quo[QW-2:0], 1'b1};
		end else begin
			r.rem = t[RW-1:0];
			r.quo = {a.quo[QW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

/* rtl/vsn_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsn_sqrt
// Pipelined integer square root, one root bit per stage, carrying the
// numerators and signs alongside.
// ----------------------------------------------------------------------------
module vsn_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  logic [vsn_pkg::SW-1:0]   sum,
	input  vsn_pkg::sqrt_side_t      in_side,
	output logic                     out_valid,
	output logic [vsn_pkg::RW-1:0]   root,
	output vsn_pkg::sqrt_side_t      out_side
);
	import vsn_pkg::*;

	logic       v_s   [RW];
	sqrt_acc_t  acc_s [RW];
	logic [SW-1:0] sum_s [RW];
	sqrt_side_t side_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic          prev_v;
		sqrt_acc_t     prev_acc;
		logic [SW-1:0] prev_sum;
		sqrt_side_t    prev_side;
		if (k == 0) begin : g_first
			assign prev_v    = in_valid;
			assign prev_acc  = '0;
			assign prev_sum  = sum;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_v    = v_s[k-1];
			assign prev_acc  = acc_s[k-1];
			assign prev_sum  = sum_s[k-1];
			assign prev_side = side_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				acc_s[k]  <= sqrt_step(prev_acc, prev_sum[2*(RW-1-k)+1 -: 2]);
				sum_s[k]  <= prev_sum;
				side_s[k] <= prev_side;
			end
		end
	end

	assign out_valid = v_s[RW-1];
	assign root      = acc_s[RW-1].root;
	assign out_side  = side_s[RW-1];

endmodule

/* rtl/vsn_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsn_div
// Three lane pipelined restoring divider, one quotient bit per stage,
// all lanes sharing the same divisor.
// ----------------------------------------------------------------------------
module vsn_div (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      adv,
	input  logic                                      in_valid,
	input  logic [vsn_pkg::LANES-1:0][vsn_pkg::NW-1:0] num,
	input  logic [vsn_pkg::RW-1:0]                    len,
	input  vsn_pkg::div_side_t                        in_side,
	output logic                                      out_valid,
	output logic [vsn_pkg::LANES-1:0][vsn_pkg::QW-1:0] quo,
	output vsn_pkg::div_side_t                        out_side
);
	import vsn_pkg::*;

	logic                     v_s    [QW];
	div_acc_t [LANES-1:0]     acc_s  [QW];
	logic [LANES-1:0][NW-1:0] num_s  [QW];
	logic [RW-1:0]            len_s  [QW];
	div_side_t                side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                     prev_v;
		div_acc_t [LANES-1:0]     prev_acc;
		logic [LANES-1:0][NW-1:0] prev_num;
		logic [RW-1:0]            prev_len;
		div_side_t                prev_side;
		div_acc_t [LANES-1:0]     next_acc;
		if (k == 0) begin : g_first
			// quotient fits QW bits, so the high numerator part starts as remainder
			for (genvar l = 0; l < LANES; l++) begin : g_init
				assign prev_acc[l].rem = num[l][NW-1:QW];
				assign prev_acc[l].quo = '0;
			end
			assign prev_v    = in_valid;
			assign prev_num  = num;
			assign prev_len  = len;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_v    = v_s[k-1];
			assign prev_acc  = acc_s[k-1];
			assign prev_num  = num_s[k-1];
			assign prev_len  = len_s[k-1];
			assign prev_side = side_s[k-1];
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			assign next_acc[l] = div_step(prev_acc[l], prev_num[l][QW-1-k], prev_len);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				acc_s[k]  <= next_acc;
				num_s[k]  <= prev_num;
				len_s[k]  <= prev_len;
				side_s[k] <= prev_side;
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quo[l] = acc_s[QW-1][l].quo;
	end
	assign out_valid = v_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

/* rtl/vector3_scaled_normalize_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_scaled_normalize_core
// Scales a signed 3D vector to a configured length: square root of the sum of
// squares, then component * target_length / length per lane.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  input     | in_valid / in_stall     | in_x, in_y, in_z
//  output    | out_valid / out_stall   | out_x, out_y, out_z, zero_length
//  config    | target_length_we        | target_length
//
//  one transaction per cycle unless a valid output is stalled; 3 front
//  stages, 32 root stages, 31 divide stages, output register
//  the root and divide stages each resolve one bit
//  arst_n clears all valid bits and loads target_length with 1.0
//  a stalled output freezes the whole pipeline; in_stall follows it
module vector3_scaled_normalize_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       target_length_we,
	input  logic [vsn_pkg::TW-1:0]     target_length,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [vsn_pkg::CW-1:0] in_x,
	input  logic signed [vsn_pkg::CW-1:0] in_y,
	input  logic signed [vsn_pkg::CW-1:0] in_z,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [vsn_pkg::CW-1:0] out_x,
	output logic signed [vsn_pkg::CW-1:0] out_y,
	output logic signed [vsn_pkg::CW-1:0] out_z,
	output logic                       zero_length
);
	import vsn_pkg::*;

	`include "vector3_scaled_normalize_core_defines.svh"

	logic                     adv;
	logic [TW-1:0]            tl_q;
	logic [LANES-1:0][CW-1:0] comp;

	logic                     v_s1, v_s2, v_s3;
	logic [LANES-1:0][CW-1:0] mag_s1;
	logic [LANES-1:0]         neg_s1, neg_s2, neg_s3;
	logic [LANES-1:0][SW-1:0] sq_s2;
	logic [LANES-1:0][NW-1:0] num_s2, num_s3;
	logic [SW-1:0]            sum_s3;

	sqrt_side_t               side_in, side_root;
	logic                     v_root;
	logic [RW-1:0]            root;
	div_side_t                dside_in, dside_out;
	logic                     v_div;
	logic [LANES-1:0][QW-1:0] quo;
	logic [LANES-1:0][CW-1:0] res;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign comp     = {in_z, in_y, in_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q <= TL_RESET;
		end else if (target_length_we) begin
			tl_q <= target_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_div;
		end
	end

	// magnitude split, squares and numerators, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				neg_s1[l] <= comp[l][CW-1];
				mag_s1[l] <= comp[l][CW-1] ? CW'(-comp[l]) : comp[l];
				sq_s2[l]  <= SW'(mag_s1[l]) * SW'(mag_s1[l]);
				num_s2[l] <= NW'(mag_s1[l]) * NW'(tl_q);
			end
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			num_s3 <= num_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	assign side_in.neg = neg_s3;
	assign side_in.num = num_s3;

	vsn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s3),
		.sum       (sum_s3),
		.in_side   (side_in),
		.out_valid (v_root),
		.root      (root),
		.out_side  (side_root)
	);

	assign dside_in.neg  = side_root.neg;
	assign dside_in.zero = (root == '0);

	vsn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_root),
		.num       (side_root.num),
		.len       (root),
		.in_side   (dside_in),
		.out_valid (v_div),
		.quo       (quo),
		.out_side  (dside_out)
	);

	// quotient never exceeds target_length, so it always fits after the sign
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (dside_out.zero) begin
				res[l] = '0;
			end else if (dside_out.neg[l]) begin
				res[l] = CW'(-{1'b0, quo[l]});
			end else begin
				res[l] = {1'b0, quo[l]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x       <= res[0];
			out_y       <= res[1];
			out_z       <= res[2];
			zero_length <= dside_out.zero;
		end
	end

	`VSN_ASSERT_NOW(a_zero_outputs, out_valid && zero_length, (out_x == 0) && (out_y == 0) && (out_z == 0), "zero length with nonzero output")
	`VSN_ASSERT_NOW(a_x_bound, out_valid && !out_x[CW-1], out_x <= CW'(tl_q), "output x exceeds target length")
	`VSN_ASSERT_NOW(a_y_bound, out_valid && out_y[CW-1], CW'(-out_y) <= CW'(tl_q), "output y exceeds target length")
	`VSN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, $stable(out_x), "stalled output changed")

endmodule
